// ----- src/clfm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clfm_pkg
// Types and fixed constants of the convolution layer forward mean block.
// ----------------------------------------------------------------------------
package clfm_pkg;

	// Operation codes of a command beat.
	typedef enum logic [1:0] {
		OP_WEIGHT  = 2'd0,
		OP_PIXEL   = 2'd1,
		OP_COMPUTE = 2'd2
	} op_t;

	// Configuration register indexes.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 6;
	localparam logic [CFG_IDX_W-1:0] REG_INPUT_HEIGHT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INPUT_WIDTH   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_HEIGHT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_WIDTH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FILTER_COUNT  = 3'd5;

	// The window holds at most 7*7*7 elements given the register widths, each
	// product stays within 2^30 in magnitude, so the sum fits in 40 bits.
	localparam int DEN_W     = 9;
	localparam int ACC_W     = 40;
	localparam int DIV_STEPS = ACC_W;
	localparam int DIV_CNT_W = 6;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_WAIT,
		ST_DIV,
		ST_RES
	} st_t;

	// One command beat.
	typedef struct packed {
		logic [1:0]         op;
		logic [2:0]         filter_index;
		logic [1:0]         channel;
		logic [4:0]         row;
		logic [4:0]         col;
		logic signed [15:0] value;
	} cmd_t;

	// One result beat.
	typedef struct packed {
		logic signed [31:0] result;
		logic               status;
	} res_t;

endpackage

// ----- src/conv_layer_forward_mean.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conv_layer_forward_mean
// Forward pass of a multichannel valid 2D convolution giving the window mean.
//
// Channel   Direction  Handshake           Beat
// cmd       in         cmd_valid/cmd_stall clfm_pkg::cmd_t (op, position, value)
// res       out        res_valid/res_stall clfm_pkg::res_t (result, status)
// cfg       in         cfg_valid/cfg_ready register index and write data
//
// A compute over the window's elements (channels * kernel rows * kernel
// columns) runs one multiply-accumulate per cycle out of the two stores,
// through a registered read and a registered multiply, then a divider that
// retires one quotient bit a cycle over 40 bits. A compute at a bad position
// skips the walk and the divider and goes straight to the result.
// Reset clears the control state and the configuration registers; the stores
// are not cleared. A stalled result waits in the output register while further
// write beats are still taken.
// ----------------------------------------------------------------------------
module conv_layer_forward_mean #(
	parameter int MAX_FILTERS  = 8,
	parameter int MAX_CHANNELS = 4,
	parameter int MAX_KERNEL   = 5,
	parameter int MAX_INPUT    = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cmd_valid,
	output logic                                cmd_stall,
	input  clfm_pkg::cmd_t                      cmd,
	output logic                                res_valid,
	input  logic                                res_stall,
	output clfm_pkg::res_t                      res,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [clfm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [clfm_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int WGT_DEPTH = MAX_FILTERS * MAX_CHANNELS * MAX_KERNEL * MAX_KERNEL;
	localparam int PIX_DEPTH = MAX_CHANNELS * MAX_INPUT * MAX_INPUT;
	localparam int WGT_AW    = (WGT_DEPTH > 1) ? $clog2(WGT_DEPTH) : 1;
	localparam int PIX_AW    = (PIX_DEPTH > 1) ? $clog2(PIX_DEPTH) : 1;
	localparam int ACC_W     = clfm_pkg::ACC_W;
	localparam int DEN_W     = clfm_pkg::DEN_W;

	// Configuration registers, kept at their raw written value.
	logic [5:0] cfg_ih_q;
	logic [5:0] cfg_iw_q;
	logic [2:0] cfg_kh_q;
	logic [2:0] cfg_kw_q;
	logic [2:0] cfg_nc_q;
	logic [3:0] cfg_nf_q;

	// Registers as used: each one saturated into 1 .. its maximum.
	logic [5:0] ih;
	logic [5:0] iw;
	logic [2:0] kh;
	logic [2:0] kw;
	logic [2:0] nc;
	logic [3:0] nf;

	clfm_pkg::st_t state_q, state_d;

	logic cmd_acc;
	logic pos_bad;
	logic issue;
	logic last_elem;
	logic div_load;
	logic res_load;
	logic out_free;

	// Latched compute position and window counters.
	logic [2:0] f_q;
	logic [4:0] r_q;
	logic [4:0] c_q;
	logic [2:0] k_q;
	logic [2:0] i_q;
	logic [2:0] j_q;
	logic       bad_q;
	logic [DEN_W-1:0] den_q;

	// Stores and their ports.
	logic [15:0] wgt_mem [WGT_DEPTH];
	logic [15:0] pix_mem [PIX_DEPTH];
	logic              wgt_we;
	logic              pix_we;
	logic [WGT_AW-1:0] wgt_wa;
	logic [PIX_AW-1:0] pix_wa;
	logic [WGT_AW-1:0] wgt_ra;
	logic [PIX_AW-1:0] pix_ra;

	// Multiply-accumulate pipeline.
	logic signed [15:0]      wgt_rd_s1;
	logic signed [15:0]      pix_rd_s1;
	logic                    valid_s1;
	logic                    last_s1;
	logic signed [31:0]      prod_s2;
	logic                    valid_s2;
	logic                    last_s2;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] sum_fin;

	// Divider: quotient shifts in where the dividend shifts out.
	logic [ACC_W-1:0]               quo_q;
	logic [DEN_W-1:0]               rem_q;
	logic                           neg_q;
	logic [clfm_pkg::DIV_CNT_W-1:0] div_cnt_q;
	logic [DEN_W:0]                 rem_sh;
	logic                           rem_ge;

	// Saturation of the signed quotient into 32 bits.
	logic        pos_ovf;
	logic        neg_ovf;
	logic [31:0] mean32;

	clfm_pkg::res_t out_q;
	logic           out_valid_q;

	// ------------------------------------------------------------------------
	// Configuration port. Writes beyond the register list are dropped.
	// ------------------------------------------------------------------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_ih_q <= 6'd32;
			cfg_iw_q <= 6'd32;
			cfg_kh_q <= 3'd3;
			cfg_kw_q <= 3'd3;
			cfg_nc_q <= 3'd1;
			cfg_nf_q <= 4'd1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				clfm_pkg::REG_INPUT_HEIGHT:  cfg_ih_q <= cfg_data;
				clfm_pkg::REG_INPUT_WIDTH:   cfg_iw_q <= cfg_data;
				clfm_pkg::REG_KERNEL_HEIGHT: cfg_kh_q <= cfg_data[2:0];
				clfm_pkg::REG_KERNEL_WIDTH:  cfg_kw_q <= cfg_data[2:0];
				clfm_pkg::REG_CHANNEL_COUNT: cfg_nc_q <= cfg_data[2:0];
				clfm_pkg::REG_FILTER_COUNT:  cfg_nf_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// A value beyond the maximum saturates to it; a saturated value never
	// exceeds the raw register, so it keeps the register's width.
	always_comb begin
		ih = (cfg_ih_q == '0) ? 6'd1 :
			(int'(cfg_ih_q) > MAX_INPUT) ? 6'(MAX_INPUT) : cfg_ih_q;
		iw = (cfg_iw_q == '0) ? 6'd1 :
			(int'(cfg_iw_q) > MAX_INPUT) ? 6'(MAX_INPUT) : cfg_iw_q;
		kh = (cfg_kh_q == '0) ? 3'd1 :
			(int'(cfg_kh_q) > MAX_KERNEL) ? 3'(MAX_KERNEL) : cfg_kh_q;
		kw = (cfg_kw_q == '0) ? 3'd1 :
			(int'(cfg_kw_q) > MAX_KERNEL) ? 3'(MAX_KERNEL) : cfg_kw_q;
		nc = (cfg_nc_q == '0) ? 3'd1 :
			(int'(cfg_nc_q) > MAX_CHANNELS) ? 3'(MAX_CHANNELS) : cfg_nc_q;
		nf = (cfg_nf_q == '0) ? 4'd1 :
			(int'(cfg_nf_q) > MAX_FILTERS) ? 4'(MAX_FILTERS) : cfg_nf_q;
	end

	// ------------------------------------------------------------------------
	// Command decode. A compute is refused with status 1 when the filter is
	// not in use or the kernel does not fit inside the input map at the
	// requested output position.
	// ------------------------------------------------------------------------
	assign cmd_acc = cmd_valid && !cmd_stall;

	assign pos_bad = ({1'b0, cmd.filter_index} >= nf) ||
		((7'(cmd.row) + 7'(kh)) > 7'(ih)) ||
		((7'(cmd.col) + 7'(kw)) > 7'(iw));

	// Writes outside the stores are dropped without a result.
	always_comb begin
		wgt_we = cmd_acc && (cmd.op == clfm_pkg::OP_WEIGHT) &&
			(int'(cmd.filter_index) < MAX_FILTERS) &&
			(int'(cmd.channel) < MAX_CHANNELS) &&
			(int'(cmd.row) < MAX_KERNEL) && (int'(cmd.col) < MAX_KERNEL);
		pix_we = cmd_acc && (cmd.op == clfm_pkg::OP_PIXEL) &&
			(int'(cmd.channel) < MAX_CHANNELS) &&
			(int'(cmd.row) < MAX_INPUT) && (int'(cmd.col) < MAX_INPUT);
		wgt_wa = WGT_AW'(((int'(cmd.filter_index) * MAX_CHANNELS + int'(cmd.channel))
			* MAX_KERNEL + int'(cmd.row)) * MAX_KERNEL + int'(cmd.col));
		pix_wa = PIX_AW'((int'(cmd.channel) * MAX_INPUT + int'(cmd.row))
			* MAX_INPUT + int'(cmd.col));
		wgt_ra = WGT_AW'(((int'(f_q) * MAX_CHANNELS + int'(k_q))
			* MAX_KERNEL + int'(i_q)) * MAX_KERNEL + int'(j_q));
		pix_ra = PIX_AW'((int'(k_q) * MAX_INPUT + int'(r_q) + int'(i_q))
			* MAX_INPUT + int'(c_q) + int'(j_q));
	end

	// ------------------------------------------------------------------------
	// Sequencer.
	// ------------------------------------------------------------------------
	assign last_elem = (k_q == nc - 3'd1) && (i_q == kh - 3'd1) && (j_q == kw - 3'd1);
	assign out_free  = !out_valid_q || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= clfm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd_stall = 1'b1;
		issue     = 1'b0;
		div_load  = 1'b0;
		res_load  = 1'b0;
		case (state_q)
			clfm_pkg::ST_IDLE: begin
				cmd_stall = 1'b0;
				if (cmd_valid && (cmd.op == clfm_pkg::OP_COMPUTE)) begin
					state_d = pos_bad ? clfm_pkg::ST_RES : clfm_pkg::ST_MAC;
				end
			end
			clfm_pkg::ST_MAC: begin
				issue = 1'b1;
				if (last_elem) begin
					state_d = clfm_pkg::ST_WAIT;
				end
			end
			clfm_pkg::ST_WAIT: begin
				if (valid_s2 && last_s2) begin
					div_load = 1'b1;
					state_d  = clfm_pkg::ST_DIV;
				end
			end
			clfm_pkg::ST_DIV: begin
				if (div_cnt_q == clfm_pkg::DIV_CNT_W'(clfm_pkg::DIV_STEPS - 1)) begin
					state_d = clfm_pkg::ST_RES;
				end
			end
			clfm_pkg::ST_RES: begin
				if (out_free) begin
					res_load = 1'b1;
					state_d  = clfm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = clfm_pkg::ST_IDLE;
			end
		endcase
	end

	// Compute position and window counters; the kernel column runs fastest,
	// then the kernel row, then the channel.
	always_ff @(posedge clk) begin
		if (cmd_acc && (cmd.op == clfm_pkg::OP_COMPUTE)) begin
			f_q   <= cmd.filter_index;
			r_q   <= cmd.row;
			c_q   <= cmd.col;
			bad_q <= pos_bad;
			den_q <= DEN_W'(nc) * DEN_W'(kh) * DEN_W'(kw);
			k_q   <= '0;
			i_q   <= '0;
			j_q   <= '0;
		end else if (issue) begin
			if (j_q == kw - 3'd1) begin
				j_q <= '0;
				if (i_q == kh - 3'd1) begin
					i_q <= '0;
					k_q <= k_q + 3'd1;
				end else begin
					i_q <= i_q + 3'd1;
				end
			end else begin
				j_q <= j_q + 3'd1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stores: one write port for load beats, one registered read port for the
	// window walk. Loads and computes never overlap, so no forwarding is
	// needed.
	// ------------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (wgt_we) begin
			wgt_mem[wgt_wa] <= cmd.value;
		end
		wgt_rd_s1 <= wgt_mem[wgt_ra];
	end

	always_ff @(posedge clk) begin
		if (pix_we) begin
			pix_mem[pix_wa] <= cmd.value;
		end
		pix_rd_s1 <= pix_mem[pix_ra];
	end

	// ------------------------------------------------------------------------
	// Multiply-accumulate: read, multiply, add.
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
			valid_s2 <= 1'b0;
			last_s2  <= 1'b0;
		end else begin
			valid_s1 <= issue;
			last_s1  <= issue && last_elem;
			valid_s2 <= valid_s1;
			last_s2  <= last_s1;
		end
	end

	assign sum_fin = acc_q + ACC_W'(prod_s2);

	always_ff @(posedge clk) begin
		prod_s2 <= pix_rd_s1 * wgt_rd_s1;
		if (cmd_acc) begin
			acc_q <= '0;
		end else if (valid_s2) begin
			acc_q <= sum_fin;
		end
	end

	// ------------------------------------------------------------------------
	// Divider: restoring, one quotient bit per cycle on the magnitude of the
	// sum, with the sign put back afterward so the quotient truncates toward
	// zero.
	// ------------------------------------------------------------------------
	assign rem_sh = {rem_q, quo_q[ACC_W-1]};
	assign rem_ge = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk) begin
		if (div_load) begin
			neg_q     <= sum_fin[ACC_W-1];
			quo_q     <= sum_fin[ACC_W-1] ? ACC_W'(-sum_fin) : ACC_W'(sum_fin);
			rem_q     <= '0;
			div_cnt_q <= '0;
		end else if (state_q == clfm_pkg::ST_DIV) begin
			div_cnt_q <= div_cnt_q + clfm_pkg::DIV_CNT_W'(1);
			quo_q     <= {quo_q[ACC_W-2:0], rem_ge};
			rem_q     <= rem_ge ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];
		end
	end

	always_comb begin
		pos_ovf = |quo_q[ACC_W-1:31];
		neg_ovf = (|quo_q[ACC_W-1:32]) || (quo_q[31] && (|quo_q[30:0]));
		if (neg_q) begin
			mean32 = neg_ovf ? 32'h8000_0000 : (32'd0 - quo_q[31:0]);
		end else begin
			mean32 = pos_ovf ? 32'h7FFF_FFFF : quo_q[31:0];
		end
	end

	// ------------------------------------------------------------------------
	// Output register.
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (!res_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_q.result <= bad_q ? 32'sd0 : $signed(mean32);
			out_q.status <= bad_q;
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

endmodule

// ----- test/conv_layer_forward_mean_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conv_layer_forward_mean_tb
// Self-checking bench for the convolution layer forward mean block. Weight
// and pixel beats fill a shadow copy of both stores, and every compute beat
// is scored against a window mean worked out here at the block's widths.
// A few directed tests cover the extremes and the error cases, then random
// layers run under bursty input traffic and a result side that stalls.
// ----------------------------------------------------------------------------
module conv_layer_forward_mean_tb;

	localparam int MAX_FILTERS  = 8;
	localparam int MAX_CHANNELS = 4;
	localparam int MAX_KERNEL   = 5;
	localparam int MAX_INPUT    = 32;

	// Op 3 has no meaning; the block has to drop it without a result.
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// Random traffic is spread over several layer shapes.
	localparam int RANDOM_BEATS  = 1750;
	localparam int LAYER_COUNT   = 10;
	localparam int BEATS_PER_LAYER = RANDOM_BEATS / LAYER_COUNT;

	// A write retires within the settle stretch, so that quiet is enough before
	// the registers change.
	localparam int SETTLE_CYCLES  = 4;
	localparam int DRAIN_CYCLES   = 200;
	localparam int HOLDOFF_CYCLES = 400;
	localparam int CYCLE_LIMIT    = 3_000_000;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            cmd_valid;
	logic                            cmd_stall;
	clfm_pkg::cmd_t                  cmd;
	logic                            res_valid;
	logic                            res_stall;
	clfm_pkg::res_t                  res;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [clfm_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [clfm_pkg::CFG_DATA_W-1:0] cfg_data;

	// Shadow copy of the layer registers, kept at their hardware widths.
	logic [5:0] cfg_in_h;
	logic [5:0] cfg_in_w;
	logic [2:0] cfg_k_h;
	logic [2:0] cfg_k_w;
	logic [2:0] cfg_chans;
	logic [3:0] cfg_filters;

	// Shadow stores, plus a flag per entry so that no compute ever reads an
	// entry that was never written.
	logic signed [15:0] weight_mem [MAX_FILTERS][MAX_CHANNELS][MAX_KERNEL][MAX_KERNEL];
	bit                 weight_set [MAX_FILTERS][MAX_CHANNELS][MAX_KERNEL][MAX_KERNEL];
	logic signed [15:0] pixel_mem  [MAX_CHANNELS][MAX_INPUT][MAX_INPUT];
	bit                 pixel_set  [MAX_CHANNELS][MAX_INPUT][MAX_INPUT];

	// Window means still owed by the block, oldest first.
	clfm_pkg::res_t pending_means [$];
	clfm_pkg::res_t next_mean;

	int          mismatch_count;
	int          useful_beats;
	int          computes_sent;
	int          burst_left;
	bit          gaps_on;
	bit          hold_request;
	int unsigned cycle_count;

	conv_layer_forward_mean #(
		.MAX_FILTERS (MAX_FILTERS),
		.MAX_CHANNELS(MAX_CHANNELS),
		.MAX_KERNEL  (MAX_KERNEL),
		.MAX_INPUT   (MAX_INPUT)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd      (cmd),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Layer shape and window mean prediction
	// ------------------------------------------------------------------------

	// A register outside its legal range is used pinned to 1..hi.
	function automatic int sat_size(input int v, input int hi);
		if (v < 1)
			return 1;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic void layer_dims(output int ih, output int iw, output int kh,
			output int kw, output int nc, output int nf);
		ih = sat_size(int'(cfg_in_h), MAX_INPUT);
		iw = sat_size(int'(cfg_in_w), MAX_INPUT);
		kh = sat_size(int'(cfg_k_h), MAX_KERNEL);
		kw = sat_size(int'(cfg_k_w), MAX_KERNEL);
		nc = sat_size(int'(cfg_chans), MAX_CHANNELS);
		nf = sat_size(int'(cfg_filters), MAX_FILTERS);
	endfunction

	function automatic bit window_fits(input int f, input int r, input int c);
		int ih, iw, kh, kw, nc, nf;
		layer_dims(ih, iw, kh, kw, nc, nf);
		return (f < nf) && (r + kh <= ih) && (c + kw <= iw);
	endfunction

	// Sum of pixel times weight over the window, divided by the element
	// count with truncation toward zero, then pinned to 32 bits. A window
	// that does not fit, or a filter past the count, yields status 1 and 0.
	function automatic clfm_pkg::res_t predict_window_mean(input clfm_pkg::cmd_t beat);
		clfm_pkg::res_t mean_beat;
		longint         acc;
		longint         mean;
		int             ih, iw, kh, kw, nc, nf;
		int             f, r, c;
		mean_beat = '0;
		f = int'(beat.filter_index);
		r = int'(beat.row);
		c = int'(beat.col);
		layer_dims(ih, iw, kh, kw, nc, nf);
		if (!window_fits(f, r, c)) begin
			mean_beat.status = 1'b1;
			return mean_beat;
		end
		acc = 0;
		for (int k = 0; k < nc; k++)
			for (int i = 0; i < kh; i++)
				for (int j = 0; j < kw; j++)
					acc += longint'(pixel_mem[k][r + i][c + j]) *
						longint'(weight_mem[f][k][i][j]);
		mean = acc / longint'(nc * kh * kw);
		if (mean > 64'sd2147483647)
			mean = 64'sd2147483647;
		if (mean < -64'sd2147483648)
			mean = -64'sd2147483648;
		mean_beat.result = mean[31:0];
		return mean_beat;
	endfunction

	// Update the shadow state for one accepted command beat. Weight writes
	// past the kernel bounds and the unused op leave no trace.
	function automatic void apply_beat(input clfm_pkg::cmd_t beat);
		case (beat.op)
			clfm_pkg::OP_WEIGHT: begin
				if (beat.row < MAX_KERNEL && beat.col < MAX_KERNEL) begin
					weight_mem[beat.filter_index][beat.channel][beat.row][beat.col] = beat.value;
					weight_set[beat.filter_index][beat.channel][beat.row][beat.col] = 1'b1;
					useful_beats++;
				end
			end
			clfm_pkg::OP_PIXEL: begin
				pixel_mem[beat.channel][beat.row][beat.col] = beat.value;
				pixel_set[beat.channel][beat.row][beat.col] = 1'b1;
				useful_beats++;
			end
			clfm_pkg::OP_COMPUTE: begin
				pending_means.push_back(predict_window_mean(beat));
				useful_beats++;
			end
			default: begin
			end
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	// Q8.8 values lean toward the extremes now and then.
	function automatic logic signed [15:0] rand_q88();
		logic [31:0] raw;
		raw = $urandom;
		case ($urandom_range(0, 9))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'sh0000;
			3: return 16'shffff;
			default: return raw[15:0];
		endcase
	endfunction

	function automatic clfm_pkg::cmd_t make_cmd(input logic [1:0] op, input int f,
			input int ch, input int r, input int c, input logic signed [15:0] v);
		clfm_pkg::cmd_t beat;
		beat.op           = op;
		beat.filter_index = f[2:0];
		beat.channel      = ch[1:0];
		beat.row          = r[4:0];
		beat.col          = c[4:0];
		beat.value        = v;
		return beat;
	endfunction

	// Offers one beat and returns at the edge that takes it. Valid stays high
	// on return so that back-to-back beats go without a bubble; it drops only in
	// a gap between bursts or where the traffic stops.
	task automatic send_cmd(input clfm_pkg::cmd_t beat);
		int gap;
		if (burst_left == 0) begin
			gap = gaps_on ? $urandom_range(0, 6) : 0;
			if (gap > 0) begin
				cmd_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		cmd_valid <= 1'b1;
		cmd       <= beat;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		apply_beat(beat);
	endtask

	// Drop valid and wait until every owed mean is back and the last write
	// has certainly retired.
	task automatic wait_idle();
		cmd_valid <= 1'b0;
		burst_left = 0;
		while (pending_means.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_beat(input logic [clfm_pkg::CFG_IDX_W-1:0] idx, input int data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data[clfm_pkg::CFG_DATA_W-1:0];
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			clfm_pkg::REG_INPUT_HEIGHT:  cfg_in_h    = data[5:0];
			clfm_pkg::REG_INPUT_WIDTH:   cfg_in_w    = data[5:0];
			clfm_pkg::REG_KERNEL_HEIGHT: cfg_k_h     = data[2:0];
			clfm_pkg::REG_KERNEL_WIDTH:  cfg_k_w     = data[2:0];
			clfm_pkg::REG_CHANNEL_COUNT: cfg_chans   = data[2:0];
			clfm_pkg::REG_FILTER_COUNT:  cfg_filters = data[3:0];
			default: begin
			end
		endcase
	endtask

	// Rewrites the whole layer shape in one run of register beats. Only
	// called while the block is idle.
	task automatic set_layer(input int ih, input int iw, input int kh, input int kw,
			input int nc, input int nf);
		cfg_beat(clfm_pkg::REG_INPUT_HEIGHT, ih);
		cfg_beat(clfm_pkg::REG_INPUT_WIDTH, iw);
		cfg_beat(clfm_pkg::REG_KERNEL_HEIGHT, kh);
		cfg_beat(clfm_pkg::REG_KERNEL_WIDTH, kw);
		cfg_beat(clfm_pkg::REG_CHANNEL_COUNT, nc);
		cfg_beat(clfm_pkg::REG_FILTER_COUNT, nf);
		cfg_valid <= 1'b0;
	endtask

	// Writes every entry that a compute at (f, r, c) would read and that has
	// never been written, with random content.
	task automatic fill_window(input int f, input int r, input int c);
		int ih, iw, kh, kw, nc, nf;
		layer_dims(ih, iw, kh, kw, nc, nf);
		for (int k = 0; k < nc; k++)
			for (int i = 0; i < kh; i++)
				for (int j = 0; j < kw; j++) begin
					if (!pixel_set[k][r + i][c + j])
						send_cmd(make_cmd(clfm_pkg::OP_PIXEL, $urandom_range(0, 7), k,
							r + i, c + j, rand_q88()));
					if (!weight_set[f][k][i][j])
						send_cmd(make_cmd(clfm_pkg::OP_WEIGHT, f, k, i, j, rand_q88()));
				end
	endtask

	// A compute beat; its channel and value fields carry noise.
	task automatic compute_at(input int f, input int r, input int c);
		if (window_fits(f, r, c))
			fill_window(f, r, c);
		send_cmd(make_cmd(clfm_pkg::OP_COMPUTE, f, $urandom_range(0, 3), r, c, rand_q88()));
		computes_sent++;
	endtask

	// One random stretch on the current layer shape. Most computes land near
	// a focus point so that stores fill once and then get reused; the rest of
	// the traffic is rewrites, noise writes and the unused op.
	task automatic run_random_phase(input int target, input bit hold_results);
		int ih, iw, kh, kw, nc, nf;
		int row_span, col_span, focus_r, focus_c;
		int start_beats, start_computes, pick, r, c;
		layer_dims(ih, iw, kh, kw, nc, nf);
		row_span = ih - kh;
		col_span = iw - kw;
		focus_r = (row_span > 0) ? $urandom_range(0, row_span) : 0;
		focus_c = (col_span > 0) ? $urandom_range(0, col_span) : 0;
		start_beats = useful_beats;
		start_computes = computes_sent;
		if (hold_results)
			hold_request = 1'b1;
		while (useful_beats - start_beats < target || computes_sent - start_computes < 12) begin
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				if (row_span < 0 || col_span < 0) begin
					r = $urandom_range(0, 31);
					c = $urandom_range(0, 31);
				end else if ($urandom_range(0, 3) == 0) begin
					r = $urandom_range(0, row_span);
					c = $urandom_range(0, col_span);
				end else begin
					r = focus_r + $urandom_range(0, 3);
					c = focus_c + $urandom_range(0, 3);
					if (r > row_span)
						r = row_span;
					if (c > col_span)
						c = col_span;
				end
				compute_at($urandom_range(0, nf - 1), r, c);
			end else if (pick < 43) begin
				compute_at($urandom_range(0, 7), $urandom_range(0, 31), $urandom_range(0, 31));
			end else if (pick < 68) begin
				send_cmd(make_cmd(clfm_pkg::OP_PIXEL, $urandom_range(0, 7),
					$urandom_range(0, nc - 1), $urandom_range(0, ih - 1),
					$urandom_range(0, iw - 1), rand_q88()));
			end else if (pick < 83) begin
				send_cmd(make_cmd(clfm_pkg::OP_WEIGHT, $urandom_range(0, nf - 1),
					$urandom_range(0, nc - 1), $urandom_range(0, kh - 1),
					$urandom_range(0, kw - 1), rand_q88()));
			end else if (pick < 90) begin
				send_cmd(make_cmd(clfm_pkg::OP_PIXEL, $urandom_range(0, 7),
					$urandom_range(0, 3), $urandom_range(0, 31), $urandom_range(0, 31),
					rand_q88()));
			end else if (pick < 95) begin
				// Weight write past the kernel bounds in one coordinate or both.
				if ($urandom_range(0, 1)) begin
					r = $urandom_range(MAX_KERNEL, 31);
					c = $urandom_range(0, 31);
				end else begin
					r = $urandom_range(0, 31);
					c = $urandom_range(MAX_KERNEL, 31);
				end
				send_cmd(make_cmd(clfm_pkg::OP_WEIGHT, $urandom_range(0, 7),
					$urandom_range(0, 3), r, c, rand_q88()));
			end else begin
				send_cmd(make_cmd(OP_UNUSED, $urandom_range(0, 7), $urandom_range(0, 3),
					$urandom_range(0, 31), $urandom_range(0, 31), rand_q88()));
			end
		end
		wait_idle();
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Reset shape is 32x32 input, 3x3 kernel, one channel, one filter: a
	// second filter and a window hanging off the bottom right corner are both errors.
	task automatic test_reset_layer();
		compute_at(1, 0, 0);
		compute_at(0, 30, 30);
	endtask

	// Single-element windows so that the product itself is the mean: the
	// largest positive product, the most negative one, at both map corners
	// and with the first and last filter.
	task automatic test_extreme_products();
		wait_idle();
		set_layer(32, 32, 1, 1, 1, 8);
		send_cmd(make_cmd(clfm_pkg::OP_WEIGHT, 0, 0, 0, 0, 16'sh8000));
		send_cmd(make_cmd(clfm_pkg::OP_PIXEL, 7, 0, 0, 0, 16'sh8000));
		compute_at(0, 0, 0);
		send_cmd(make_cmd(clfm_pkg::OP_WEIGHT, 7, 3, 4, 4, 16'sh7fff));
		send_cmd(make_cmd(clfm_pkg::OP_PIXEL, 0, 3, 31, 31, 16'sh7fff));
		send_cmd(make_cmd(clfm_pkg::OP_WEIGHT, 7, 0, 0, 0, 16'sh7fff));
		send_cmd(make_cmd(clfm_pkg::OP_PIXEL, 0, 0, 31, 31, 16'sh8000));
		compute_at(7, 31, 31);
	endtask

	// A weight write past the kernel bounds and the unused op must not
	// disturb anything: the earlier window is read back unchanged.
	task automatic test_ignored_beats();
		send_cmd(make_cmd(clfm_pkg::OP_WEIGHT, 0, 0, 31, 31, 16'sh5555));
		send_cmd(make_cmd(clfm_pkg::OP_WEIGHT, 0, 0, 0, 5, 16'sh1234));
		send_cmd(make_cmd(OP_UNUSED, 0, 0, 0, 0, 16'sh7fff));
		compute_at(0, 0, 0);
	endtask

	// Filter past the count, and windows hanging off the bottom, the right
	// and the far corner of a 16x16 map with a 5x5 kernel.
	task automatic test_bad_positions();
		wait_idle();
		set_layer(16, 16, 5, 5, 1, 2);
		compute_at(2, 0, 0);
		compute_at(0, 12, 0);
		compute_at(1, 0, 12);
		compute_at(7, 31, 31);
	endtask

	// Zero in every register acts as 1; the top codes act as the maxima.
	task automatic test_register_saturation();
		wait_idle();
		set_layer(0, 0, 0, 0, 0, 0);
		compute_at(0, 0, 0);
		compute_at(1, 0, 0);
		compute_at(0, 0, 1);
		wait_idle();
		set_layer(63, 63, 7, 7, 7, 15);
		compute_at(7, 27, 0);
		compute_at(0, 0, 27);
		compute_at(7, 28, 0);
	endtask

	// Smallest layer, steady input and a long hold on the result side, so
	// the output register fills and the block pushes back on commands.
	task automatic test_backpressure();
		wait_idle();
		gaps_on = 1'b0;
		set_layer(1, 1, 1, 1, 1, 1);
		run_random_phase(BEATS_PER_LAYER, 1'b1);
	endtask

	// Random layer shapes: the saturated top codes, the legal maxima, a
	// lopsided one, then mostly small maps with the occasional large one.
	task automatic test_random_layers();
		int ih, iw;
		for (int layer = 1; layer < LAYER_COUNT; layer++) begin
			wait_idle();
			gaps_on = ($urandom_range(0, 3) != 0);
			if (layer == 1) begin
				set_layer(63, 63, 7, 7, 7, 15);
			end else if (layer == 2) begin
				set_layer(32, 32, 5, 5, 4, 8);
			end else if (layer == 3) begin
				set_layer(1, 32, 1, 5, 1, 8);
			end else begin
				ih = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 10);
				iw = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 10);
				set_layer(ih, iw, $urandom_range(0, 7), $urandom_range(0, 7),
					$urandom_range(0, 7), $urandom_range(0, 15));
			end
			run_random_phase(BEATS_PER_LAYER, 1'b0);
		end
	endtask

	// ------------------------------------------------------------------------
	// Result side: stall pattern and scoring
	// ------------------------------------------------------------------------

	// The result side picks a stall style for a random stretch: none, light
	// random, heavy random, or a fixed three-of-five pattern. A hold request
	// from the stimulus overrides it for the whole hold-off stretch.
	initial begin : result_stall_gen
		int mode;
		int stretch_left;
		int hold_left;
		res_stall = 1'b0;
		mode = 0;
		stretch_left = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLDOFF_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_stall <= 1'b1;
			end else begin
				if (stretch_left == 0) begin
					mode = $urandom_range(0, 3);
					stretch_left = $urandom_range(20, 200);
				end
				stretch_left--;
				case (mode)
					0: res_stall <= 1'b0;
					1: res_stall <= ($urandom_range(0, 99) < 30);
					2: res_stall <= ($urandom_range(0, 99) < 75);
					default: res_stall <= ((stretch_left % 5) < 3);
				endcase
			end
		end
	end

	// Every result beat taken is scored against the oldest owed mean.
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (pending_means.size() == 0) begin
				$error("result beat with nothing owed: result %0d status %0d",
					res.result, res.status);
				mismatch_count++;
			end else begin
				next_mean = pending_means.pop_front();
				if (res.result !== next_mean.result) begin
					$error("result: expected %0d, got %0d", next_mean.result, res.result);
					mismatch_count++;
				end
				if (res.status !== next_mean.status) begin
					$error("status: expected %0d, got %0d", next_mean.status, res.status);
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog against a hung handshake.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("conv_layer_forward_mean verification failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n    = 1'b0;
		cmd_valid = 1'b0;
		cmd       = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		// Register values that reset leaves behind.
		cfg_in_h    = 6'd32;
		cfg_in_w    = 6'd32;
		cfg_k_h     = 3'd3;
		cfg_k_w     = 3'd3;
		cfg_chans   = 3'd1;
		cfg_filters = 4'd1;
		mismatch_count = 0;
		useful_beats   = 0;
		computes_sent  = 0;
		burst_left     = 0;
		gaps_on        = 1'b1;
		hold_request   = 1'b0;
		cycle_count    = 0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_layer();
		test_extreme_products();
		test_ignored_beats();
		test_bad_positions();
		test_register_saturation();
		test_backpressure();
		test_random_layers();

		cmd_valid <= 1'b0;
		while (pending_means.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_means.size() != 0) begin
			$error("%0d window means never arrived", pending_means.size());
			mismatch_count++;
		end

		if (mismatch_count == 0)
			$display("conv_layer_forward_mean verification clean");
		else
			$display("conv_layer_forward_mean verification failed");
		$finish;
	end

endmodule
